>>> rtl/core/bba_pkg.sv
package bba_pkg;

  localparam logic [1:0] ACT_INIT  = 2'd0;
  localparam logic [1:0] ACT_ALLOC = 2'd1;
  localparam logic [1:0] ACT_FREE  = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADORD  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_ASCAN,
    S_APOP,
    S_APOPW,
    S_ASPLIT,
    S_FSTART,
    S_FWALK,
    S_FWAIT,
    S_FPUSH,
    S_DONE
  } state_t;

endpackage

>>> rtl/core/buddy_block_allocator.sv
// Buddy block allocator over a pool of POOL_BLOCKS blocks.
// Requests come in on s_axis (action, order, block_index); each request gives
// one response on m_axis (status, granted_index).
// managed_blocks is written through cfg_we/cfg_wdata, only while idle (a user
// rule the block does not enforce), and takes effect at the next init request.
// One request is handled at a time by a small sequencer around a single
// link memory (one write port, registered read).
// Work from the accepting transfer to the response:
//   init     : one order per cycle, largest first
//   allocate : order scan, pop, one split a cycle
//   free     : a rejected request skips the walk; else, per order visited, a
//              walk of that order's list for the buddy, bounded by POOL_BLOCKS
// s_axis_tready is high only in the idle state. The response is held in an
// output register until m_axis_tready takes it; the block stays busy until
// then, and the next request can be accepted in the cycle after that transfer.
// Reset loads managed_blocks with 1024 and then runs an init that gives no
// response, so the first request is accepted only once that init is done.
// Link entries are only read after being written, so the memory needs no
// clearing pass.
module buddy_block_allocator #(
  parameter int POOL_BLOCKS = 1024,
  parameter int ORDER_COUNT = 11
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action[1:0], order[5:2], block_index[15:6]
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], granted_index[11:2], zero fill [15:12]
  output logic [15:0] m_axis_tdata
);

  localparam int AW = $clog2(POOL_BLOCKS);
  localparam int OW = $clog2(ORDER_COUNT + 1);
  localparam int CW = AW + 1;

  bba_pkg::state_t state, state_next;

  logic [10:0]   managed_blocks;
  logic [CW-1:0] pool_count;
  logic [OW-1:0] order_limit;
  logic [AW-1:0] free_head [ORDER_COUNT];
  logic          head_ok [ORDER_COUNT];
  logic          boot_init;

  logic [1:0]    act;
  logic [3:0]    ord_in;
  logic [OW-1:0] ord;
  logic [AW-1:0] bidx;
  logic [OW-1:0] k;
  logic [CW-1:0] pos;
  logic [AW-1:0] cur;
  logic [AW-1:0] base;
  logic [AW-1:0] walk;
  logic [AW-1:0] prev;
  logic          have_prev;
  logic [CW-1:0] steps;
  logic [1:0]    status;
  logic [9:0]    granted;

  // link memory: {valid, successor}
  logic          lm_we;
  logic [AW-1:0] lm_waddr, lm_raddr;
  logic [AW:0]   lm_wdata, lm_rdata;

  bba_ram #(.WIDTH(AW + 1), .DEPTH(POOL_BLOCKS)) u_links (
    .clk(clk), .we(lm_we), .waddr(lm_waddr), .wdata(lm_wdata),
    .raddr(lm_raddr), .rdata(lm_rdata)
  );

  logic [CW-1:0] sat_count;
  logic [OW-1:0] lim_calc;
  logic [AW-1:0] buddy;
  logic [CW-1:0] half;
  logic          ord_bad;
  logic          chunk_set;
  logic          found;

  assign sat_count = (32'(managed_blocks) > POOL_BLOCKS) ? CW'(POOL_BLOCKS)
                                                        : CW'(managed_blocks);
  assign buddy = cur ^ (AW'(1) << k);
  assign half  = CW'(base) + (CW'(1) << (k - OW'(1)));
  assign ord_bad = (32'(ord_in) >= 32'(order_limit));
  assign found = (walk == buddy);

  // init places a chunk at this order
  assign chunk_set = (k != '0) && (k <= lim_calc) && sat_count[k - OW'(1)];

  // order count: floor(log2(count))+1 capped
  always_comb begin
    lim_calc = '0;
    for (int i = 0; i < ORDER_COUNT; i++) begin
      if ((sat_count >> i) != '0) lim_calc = OW'(i + 1);
    end
  end

  assign s_axis_tready = (state == bba_pkg::S_IDLE);
  assign m_axis_tvalid = (state == bba_pkg::S_DONE);
  assign m_axis_tdata  = {4'd0, granted, status};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bba_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tdata[1:0] == bba_pkg::ACT_INIT) state_next = bba_pkg::S_INIT;
          else if (s_axis_tdata[1:0] == bba_pkg::ACT_ALLOC ||
                   s_axis_tdata[1:0] == bba_pkg::ACT_FREE) state_next = bba_pkg::S_ASCAN;
          else state_next = bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_INIT: begin
        if (k == '0) state_next = boot_init ? bba_pkg::S_IDLE : bba_pkg::S_DONE;
      end
      bba_pkg::S_ASCAN: begin
        if (act == bba_pkg::ACT_ALLOC) begin
          if (ord_bad) state_next = bba_pkg::S_DONE;
          else if (k >= order_limit) state_next = bba_pkg::S_DONE;
          else if (head_ok[k]) state_next = bba_pkg::S_APOP;
        end else begin
          if (ord_bad) state_next = bba_pkg::S_DONE;
          else if (CW'(bidx) >= pool_count) state_next = bba_pkg::S_DONE;
          else state_next = bba_pkg::S_FSTART;
        end
      end
      bba_pkg::S_APOP:   state_next = bba_pkg::S_APOPW;
      bba_pkg::S_APOPW:  state_next = bba_pkg::S_ASPLIT;
      bba_pkg::S_ASPLIT: if (k == ord) state_next = bba_pkg::S_DONE;
      bba_pkg::S_FSTART: begin
        if (k + OW'(1) >= order_limit || !head_ok[k]) state_next = bba_pkg::S_FPUSH;
        else state_next = bba_pkg::S_FWALK;
      end
      bba_pkg::S_FWALK: begin
        if (walk == buddy || steps >= CW'(POOL_BLOCKS)) begin
          if (walk == buddy) state_next = bba_pkg::S_FWAIT;
          else state_next = bba_pkg::S_FPUSH;
        end else state_next = bba_pkg::S_FWAIT;
      end
      // link of the visited entry is back: merge, end of list, or go on
      bba_pkg::S_FWAIT: begin
        if (found) state_next = bba_pkg::S_FSTART;
        else if (!lm_rdata[AW]) state_next = bba_pkg::S_FPUSH;
        else state_next = bba_pkg::S_FWALK;
      end
      bba_pkg::S_FPUSH: state_next = bba_pkg::S_DONE;
      bba_pkg::S_DONE:  if (m_axis_tready) state_next = bba_pkg::S_IDLE;
      default:          state_next = bba_pkg::S_IDLE;
    endcase
  end

  // link memory port control
  always_comb begin
    lm_we    = 1'b0;
    lm_waddr = '0;
    lm_wdata = '0;
    lm_raddr = walk;
    unique case (state)
      bba_pkg::S_INIT: begin
        if (chunk_set && pos < CW'(POOL_BLOCKS)) begin
          lm_we    = 1'b1;
          lm_waddr = AW'(pos);
          lm_wdata = '0;
        end
      end
      bba_pkg::S_APOP:   lm_raddr = free_head[k];
      bba_pkg::S_APOPW: begin
        lm_we    = 1'b1;
        lm_waddr = base;
        lm_wdata = '0;
      end
      bba_pkg::S_ASPLIT: begin
        if (k != ord && half < CW'(POOL_BLOCKS)) begin
          lm_we    = 1'b1;
          lm_waddr = AW'(half);
          lm_wdata = {head_ok[k - OW'(1)], free_head[k - OW'(1)]};
        end
      end
      bba_pkg::S_FWALK:  lm_raddr = walk;
      bba_pkg::S_FWAIT: begin
        if (found) begin
          // unlink: predecessor takes the buddy's successor
          if (have_prev) begin
            lm_we    = 1'b1;
            lm_waddr = prev;
            lm_wdata = lm_rdata;
          end
        end
      end
      bba_pkg::S_FPUSH: begin
        lm_we    = 1'b1;
        lm_waddr = cur;
        lm_wdata = {head_ok[k], free_head[k]};
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= bba_pkg::S_INIT;
      boot_init      <= 1'b1;
      managed_blocks <= 11'd1024;
      k              <= OW'(ORDER_COUNT);
      pos            <= '0;
      pool_count     <= '0;
      order_limit    <= '0;
      status         <= bba_pkg::ST_DONE;
      granted        <= '0;
      for (int i = 0; i < ORDER_COUNT; i++) begin
        head_ok[i]   <= 1'b0;
        free_head[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) managed_blocks <= cfg_wdata;
      // the init after reset answers nothing
      if (state == bba_pkg::S_INIT && k == '0) boot_init <= 1'b0;
      unique case (state)
        bba_pkg::S_IDLE: begin
          act     <= s_axis_tdata[1:0];
          ord_in  <= s_axis_tdata[5:2];
          ord     <= OW'(s_axis_tdata[5:2]);
          k       <= (s_axis_tvalid && s_axis_tdata[1:0] == bba_pkg::ACT_INIT) ?
                     OW'(ORDER_COUNT) : OW'(s_axis_tdata[5:2]);
          bidx    <= AW'(s_axis_tdata[15:6]);
          cur     <= AW'(s_axis_tdata[15:6]);
          status  <= bba_pkg::ST_DONE;
          granted <= '0;
          pos     <= '0;
        end
        bba_pkg::S_INIT: begin
          // one order per cycle, largest first
          if (k == OW'(ORDER_COUNT)) begin
            pool_count  <= sat_count;
            order_limit <= lim_calc;
          end
          for (int i = 0; i < ORDER_COUNT; i++) begin
            if (chunk_set && OW'(i) == k - OW'(1)) head_ok[i] <= 1'b1;
            else if (k == OW'(ORDER_COUNT)) head_ok[i] <= 1'b0;
          end
          if (chunk_set) begin
            free_head[k - OW'(1)] <= AW'(pos);
            pos <= pos + (CW'(1) << (k - OW'(1)));
          end
          if (k != '0) k <= k - OW'(1);
        end
        bba_pkg::S_ASCAN: begin
          if (act == bba_pkg::ACT_ALLOC) begin
            if (ord_bad) status <= bba_pkg::ST_BADORD;
            else if (k >= order_limit) status <= bba_pkg::ST_NOSPACE;
            else if (!head_ok[k]) k <= k + OW'(1);
          end else begin
            if (ord_bad) status <= bba_pkg::ST_BADORD;
          end
        end
        bba_pkg::S_APOP: base <= free_head[k];
        bba_pkg::S_APOPW: begin
          head_ok[k]   <= lm_rdata[AW];
          free_head[k] <= lm_rdata[AW] ? lm_rdata[AW-1:0] : '0;
        end
        bba_pkg::S_ASPLIT: begin
          if (k == ord) begin
            granted <= 10'(base);
          end else begin
            if (half < CW'(POOL_BLOCKS)) begin
              head_ok[k - OW'(1)]   <= 1'b1;
              free_head[k - OW'(1)] <= AW'(half);
            end
            k <= k - OW'(1);
          end
        end
        bba_pkg::S_FSTART: begin
          walk      <= free_head[k];
          have_prev <= 1'b0;
          steps     <= '0;
        end
        bba_pkg::S_FWALK: steps <= steps + CW'(1);
        bba_pkg::S_FWAIT: begin
          if (found) begin
            if (!have_prev) begin
              head_ok[k]   <= lm_rdata[AW];
              free_head[k] <= lm_rdata[AW] ? lm_rdata[AW-1:0] : '0;
            end
            cur <= cur & ~(AW'(1) << k);
            k   <= k + OW'(1);
          end else begin
            prev      <= walk;
            have_prev <= 1'b1;
            walk      <= lm_rdata[AW-1:0];
          end
        end
        bba_pkg::S_FPUSH: begin
          head_ok[k]   <= 1'b1;
          free_head[k] <= cur;
        end
        default: ;
      endcase
    end
  end

  // no response is offered while a request can be accepted
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("request and response both open");

  // a stalled response holds its payload
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("response changed while stalled");

  // granted index only with success
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && status != bba_pkg::ST_DONE |-> granted == '0)
    else $error("index granted with error status");

  // order limit never exceeds the order count
  assert property (@(posedge clk) disable iff (rst)
    order_limit <= OW'(ORDER_COUNT))
    else $error("order limit out of range");

endmodule

>>> rtl/core/bba_ram.sv
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
